FILE: rtl/mkd_pkg.sv
// shared types, constants and letter table for the morse key decoder
`default_nettype none

package mkd_pkg;

   // field and state widths
   localparam int CountWidth  = 8;
   localparam int IndexWidth  = 5;
   localparam int CodeWidth   = 7;
   localparam int CsrIdxWidth = 8;

   // longest letter in symbols, clipped to what the tree index can hold
   localparam int MAX_SYMBOLS  = 4;
   localparam int TreeDepth    = IndexWidth - 1;
   localparam int SymbolLimit  = (MAX_SYMBOLS < TreeDepth) ? MAX_SYMBOLS : TreeDepth;
   localparam logic [IndexWidth-1:0] FullIndex = IndexWidth'(1 << SymbolLimit);

   // register indexes on the csr port
   localparam logic [CsrIdxWidth-1:0] CSR_DASH_THRESHOLD = CsrIdxWidth'(0);
   localparam logic [CsrIdxWidth-1:0] CSR_GAP_TICKS      = CsrIdxWidth'(1);

   // reset values
   localparam logic [CountWidth-1:0] DashThresholdReset = CountWidth'(3);
   localparam logic [CountWidth-1:0] GapTicksReset      = CountWidth'(5);
   localparam logic [IndexWidth-1:0] TreeRoot           = IndexWidth'(1);
   localparam logic [CountWidth-1:0] CountMax           = {CountWidth{1'b1}};

   localparam logic [CodeWidth-1:0] CharSpace = 7'h20;

   // decoder state carried from one tick to the next
   typedef struct packed {
      logic [CountWidth-1:0] press_ticks;
      logic [CountWidth-1:0] idle_ticks;
      logic [IndexWidth-1:0] tree_index;
      logic                  symbol_overflow;
   } mkd_state_type;

   // result of one tick
   typedef struct packed {
      logic                 too_long;
      logic [CodeWidth-1:0] letter_code;
      logic                 letter_valid;
      logic                 dash_seen;
      logic                 dot_seen;
   } mkd_result_type;

   // letter at a position of the morse tree, space where there is none
   function automatic logic [CodeWidth-1:0] letter_at(input logic [IndexWidth-1:0] idx);
      logic [CodeWidth-1:0] ch;
      unique case (idx)
         5'd2:    ch = 7'h65; // e
         5'd3:    ch = 7'h74; // t
         5'd4:    ch = 7'h69; // i
         5'd5:    ch = 7'h61; // a
         5'd6:    ch = 7'h6e; // n
         5'd7:    ch = 7'h6d; // m
         5'd8:    ch = 7'h73; // s
         5'd9:    ch = 7'h75; // u
         5'd10:   ch = 7'h72; // r
         5'd11:   ch = 7'h77; // w
         5'd12:   ch = 7'h64; // d
         5'd13:   ch = 7'h6b; // k
         5'd14:   ch = 7'h67; // g
         5'd15:   ch = 7'h6f; // o
         5'd16:   ch = 7'h68; // h
         5'd17:   ch = 7'h76; // v
         5'd18:   ch = 7'h66; // f
         5'd20:   ch = 7'h6c; // l
         5'd22:   ch = 7'h70; // p
         5'd23:   ch = 7'h6a; // j
         5'd24:   ch = 7'h62; // b
         5'd25:   ch = 7'h78; // x
         5'd26:   ch = 7'h63; // c
         5'd27:   ch = 7'h79; // y
         5'd28:   ch = 7'h7a; // z
         5'd29:   ch = 7'h71; // q
         default: ch = CharSpace;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/mkd_step.sv
// next-state and result logic for one sampling tick
`default_nettype none

module mkd_step (
   input  wire mkd_pkg::mkd_state_type                  cur,
   input  wire                                          key_down,
   input  wire logic [mkd_pkg::CountWidth-1:0]          dash_threshold,
   input  wire logic [mkd_pkg::CountWidth-1:0]          gap_ticks,
   output mkd_pkg::mkd_state_type                       nxt,
   output mkd_pkg::mkd_result_type                      res
);

   logic rose;
   logic is_dash;

   always_comb begin
      nxt     = cur;
      res     = '0;
      rose    = 1'b0;
      is_dash = 1'b0;

      // press and idle counters, both saturating
      if (key_down) begin
         nxt.idle_ticks = '0;
         if (cur.press_ticks != mkd_pkg::CountMax) begin
            nxt.press_ticks = cur.press_ticks + 1'b1;
         end
      end else begin
         if (cur.idle_ticks != mkd_pkg::CountMax) begin
            nxt.idle_ticks = cur.idle_ticks + 1'b1;
            rose           = 1'b1;
         end
         // release ends a press: append dot or dash, or flag overflow if the letter is full
         if (cur.press_ticks != '0) begin
            is_dash       = (cur.press_ticks >= dash_threshold);
            res.dash_seen = is_dash;
            res.dot_seen  = !is_dash;
            if (cur.tree_index >= mkd_pkg::FullIndex) begin
               nxt.symbol_overflow = 1'b1;
            end else begin
               nxt.tree_index = {cur.tree_index[mkd_pkg::IndexWidth-2:0], is_dash};
            end
         end
         nxt.press_ticks = '0;
      end

      // gap reached: emit the letter and return to the root
      if (rose && (nxt.idle_ticks == gap_ticks)) begin
         res.letter_valid = 1'b1;
         res.too_long     = nxt.symbol_overflow;
         res.letter_code  = nxt.symbol_overflow ? mkd_pkg::CharSpace
                                                : mkd_pkg::letter_at(nxt.tree_index);
         nxt.tree_index      = mkd_pkg::TreeRoot;
         nxt.symbol_overflow = 1'b0;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/morse_key_decoder_core.sv
// morse key decoder top level: one result per sampling tick
// output: the result of a tick is registered in the output register when the tick is taken
// throughput: one tick per clock, set by the single state update per cycle, unless
//   a held result stalls; a new tick enters as the previous result is being taken
// reset: synchronous active-high reset clears counters, returns the tree to the root,
//   loads dash_threshold 3 and gap_ticks 5, and empties the output register
`default_nettype none

module morse_key_decoder_core (
   input  wire        clock,
   input  wire        reset,
   // sampling ticks
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire [7:0]  req_tdata,   // [0] key_down
   // results
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [15:0] rsp_tdata,  // [0] dot_seen, [1] dash_seen, [2] letter_valid,
                                   // [9:3] letter_code, [10] too_long
   // register writes
   input  wire        csr_valid,
   output logic       csr_ready,
   input  wire [mkd_pkg::CsrIdxWidth-1:0] csr_index,
   input  wire [mkd_pkg::CountWidth-1:0]  csr_data
);

   mkd_pkg::mkd_state_type  state_ff, state_in;
   mkd_pkg::mkd_result_type res_in, rsp_data_ff;
   logic [mkd_pkg::CountWidth-1:0] dash_threshold_ff;
   logic [mkd_pkg::CountWidth-1:0] gap_ticks_ff;
   logic rsp_valid_ff;
   logic req_fire;

   // accept a tick whenever the output register is free or being drained
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   mkd_step u_step (
      .cur            (state_ff),
      .key_down       (req_tdata[0]),
      .dash_threshold (dash_threshold_ff),
      .gap_ticks      (gap_ticks_ff),
      .nxt            (state_in),
      .res            (res_in)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dash_threshold_ff <= mkd_pkg::DashThresholdReset;
         gap_ticks_ff      <= mkd_pkg::GapTicksReset;
      end else if (csr_valid) begin
         if (csr_index == mkd_pkg::CSR_DASH_THRESHOLD) begin
            dash_threshold_ff <= csr_data;
         end
         if (csr_index == mkd_pkg::CSR_GAP_TICKS) begin
            gap_ticks_ff <= csr_data;
         end
      end
   end

   // decoder state advances on each accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.press_ticks     <= '0;
         state_ff.idle_ticks      <= '0;
         state_ff.tree_index      <= mkd_pkg::TreeRoot;
         state_ff.symbol_overflow <= 1'b0;
      end else if (req_fire) begin
         state_ff <= state_in;
      end
   end

   // output register control
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= res_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_data_ff};

endmodule

`default_nettype wire

FILE: tb/sv/morse_key_decoder_core_test.sv
// self-checking testbench for the morse key decoder core
`timescale 1ns / 1ps

module morse_key_decoder_core_test;

   localparam int QuietLimit = 2000;
   localparam logic [7:0] CountTop = 8'hff;
   localparam int LetterLimit = 4;
   // letters along the morse tree, position 0 first
   localparam logic [8*32-1:0] MorseText = "  etianmsurwdkgohvf l pjbxcyzq  ";

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = '0;      // [0] key_down
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;          // [0] dot_seen, [1] dash_seen, [2] letter_valid,
                                    // [9:3] letter_code, [10] too_long
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [mkd_pkg::CsrIdxWidth-1:0] csr_index = '0;
   logic [mkd_pkg::CountWidth-1:0] csr_data = '0;

   // decoder shadow state and register copies
   logic [7:0] hold_ticks = '0;
   logic [7:0] silent_ticks = '0;
   logic [4:0] tree_pos = 5'd1;
   logic overflowed = 1'b0;
   logic [7:0] dash_min = 8'd3;
   logic [7:0] gap_len = 8'd5;

   // key levels waiting to be sent and decoder outputs waiting to arrive
   logic key_q[$];
   mkd_pkg::mkd_result_type decoded_q[$];
   int ticks_queued = 0;
   int ticks_taken = 0;
   int mismatches = 0;
   int quiet_cycles = 0;
   int send_idle_pct = 6;
   int recv_stall_pct = 85;

   morse_key_decoder_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // walk one step down the tree unless the letter is already full
   function automatic void add_symbol(input logic is_dash);
      logic [4:0] p;
      int depth;
      p = tree_pos;
      depth = 0;
      while (p > 5'd1) begin
         p = p >> 1;
         depth = depth + 1;
      end
      if (depth >= mkd_pkg::MAX_SYMBOLS || depth >= LetterLimit) overflowed = 1'b1;
      else tree_pos = {tree_pos[3:0], is_dash};
   endfunction

   // advance the shadow decoder by one sampling tick
   function automatic mkd_pkg::mkd_result_type decode_tick(input logic key);
      mkd_pkg::mkd_result_type r;
      logic idle_rose;
      r = '0;
      idle_rose = 1'b0;
      if (key) begin
         silent_ticks = '0;
         if (hold_ticks != CountTop) hold_ticks = hold_ticks + 8'd1;
      end else begin
         if (silent_ticks != CountTop) begin
            silent_ticks = silent_ticks + 8'd1;
            idle_rose = 1'b1;
         end
         if (hold_ticks != 8'd0) begin
            if (hold_ticks < dash_min) begin
               r.dot_seen = 1'b1;
               add_symbol(1'b0);
            end else begin
               r.dash_seen = 1'b1;
               add_symbol(1'b1);
            end
         end
         hold_ticks = '0;
      end
      // letter gap reached on this tick
      if (idle_rose && silent_ticks == gap_len) begin
         r.letter_valid = 1'b1;
         if (overflowed) begin
            r.letter_code = mkd_pkg::CharSpace;
            r.too_long = 1'b1;
         end else begin
            r.letter_code = MorseText[8*(31-int'(tree_pos)) +: 7];
         end
         tree_pos = 5'd1;
         overflowed = 1'b0;
      end
      return r;
   endfunction

   // tick driver: predicts on each accepted transaction
   always @(posedge clock) begin : tick_driver
      logic next_valid;
      logic [7:0] next_data;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         next_valid = req_tvalid;
         next_data = req_tdata;
         if (req_tvalid && req_tready) begin
            decoded_q.push_back(decode_tick(req_tdata[0]));
            ticks_taken = ticks_taken + 1;
            next_valid = 1'b0;
         end
         if (!next_valid && key_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            next_valid = 1'b1;
            next_data = {7'b0, key_q.pop_front()};
         end
         req_tvalid <= next_valid;
         req_tdata <= next_data;
      end
   end

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         mismatches = mismatches + 1;
         if (mismatches <= 10)
            $display("mismatch in %s: expected %0d, got %0d", name, want, got);
      end
   endtask

   // result monitor with random backpressure
   always @(posedge clock) begin : result_monitor
      mkd_pkg::mkd_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (decoded_q.size() == 0) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10)
                  $display("unexpected result transaction: got %h", rsp_tdata);
            end else begin
               want = decoded_q.pop_front();
               check_field("dot_seen", int'(want.dot_seen), int'(rsp_tdata[0]));
               check_field("dash_seen", int'(want.dash_seen), int'(rsp_tdata[1]));
               check_field("letter_valid", int'(want.letter_valid), int'(rsp_tdata[2]));
               check_field("letter_code", int'(want.letter_code), int'(rsp_tdata[9:3]));
               check_field("too_long", int'(want.too_long), int'(rsp_tdata[10]));
               check_field("pad bits", 0, int'(rsp_tdata[15:11]));
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // watchdog on cycles with no transaction anywhere
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("FAIL morse_key_decoder_core");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_run(input logic key, input int n);
      repeat (n) begin
         key_q.push_back(key);
         ticks_queued = ticks_queued + 1;
      end
   endtask

   // length near the edges of a range, sometimes exactly on them
   function automatic int edge_len(input int lo, input int hi);
      case ($urandom_range(0, 3))
         0: return lo;
         1: return hi;
         default: return $urandom_range(lo, (hi - lo > 6) ? lo + 6 : hi);
      endcase
   endfunction

   // one well-formed letter at the current timing, up to six symbols
   task automatic send_letter();
      int nsym;
      int len;
      nsym = $urandom_range(0, 6);
      if (gap_len == 8'd1 && nsym > 1) nsym = 1;
      for (int i = 0; i < nsym; i++) begin
         if (i > 0) push_run(1'b0, edge_len(1, int'(gap_len) - 1));
         if ($urandom_range(0, 1) == 0 && dash_min > 8'd1) begin
            push_run(1'b1, edge_len(1, int'(dash_min) - 1));
         end else begin
            // now and then hold long enough to saturate the press counter
            len = ($urandom_range(0, 49) == 0) ? $urandom_range(256, 270)
                                               : edge_len(int'(dash_min), int'(dash_min) + 3);
            push_run(1'b1, len);
         end
      end
      len = ($urandom_range(0, 49) == 0) ? $urandom_range(256, 270)
                                         : edge_len(int'(gap_len), int'(gap_len) + 3);
      push_run(1'b0, len);
   endtask

   // mostly letters, some random key noise
   task automatic random_ticks(input int budget);
      int target;
      target = ticks_queued + budget;
      while (ticks_queued < target) begin
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 12)) push_run(1'($urandom_range(0, 1)), 1);
         end else begin
            send_letter();
         end
      end
   endtask

   // hold off until every tick is taken and every result has arrived
   task automatic settle();
      while (ticks_taken != ticks_queued || decoded_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input logic [mkd_pkg::CsrIdxWidth-1:0] idx, input logic [7:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         mkd_pkg::CSR_DASH_THRESHOLD: dash_min = val;
         mkd_pkg::CSR_GAP_TICKS: gap_len = val;
         default: ;
      endcase
   endtask

   task automatic retune(input logic [7:0] thr, input logic [7:0] gap);
      settle();
      write_reg(mkd_pkg::CSR_DASH_THRESHOLD, thr);
      write_reg(mkd_pkg::CSR_GAP_TICKS, gap);
   endtask

   initial begin : stimulus
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset timing: space from an empty gap, then a five symbol letter
      push_run(1'b0, 5);
      push_run(1'b1, 3);
      push_run(1'b0, 1);
      push_run(1'b1, 2);
      push_run(1'b0, 1);
      push_run(1'b1, 3);
      push_run(1'b0, 1);
      push_run(1'b1, 1);
      push_run(1'b0, 1);
      push_run(1'b1, 1);
      push_run(1'b0, 5);
      random_ticks(300);

      // shortest settings: release and gap land on the same tick
      retune(8'd1, 8'd1);
      push_run(1'b1, 1);
      push_run(1'b0, 2);
      random_ticks(250);

      send_idle_pct = 85;
      recv_stall_pct = 6;
      retune(8'd255, 8'd12);
      random_ticks(350);
      retune(8'd2, 8'd255);
      random_ticks(350);

      send_idle_pct = 0;
      recv_stall_pct = 0;
      retune(8'($urandom_range(1, 12)), 8'($urandom_range(1, 16)));
      random_ticks(300);
      retune(8'($urandom_range(1, 12)), 8'($urandom_range(1, 16)));
      random_ticks(250);

      settle();
      if (mismatches == 0 && decoded_q.size() == 0) begin
         $display("PASS morse_key_decoder_core");
      end else begin
         $display("FAIL morse_key_decoder_core");
      end
      $finish;
   end

endmodule

FILE: morse_key_decoder_core.f
rtl/mkd_pkg.sv
rtl/mkd_step.sv
rtl/morse_key_decoder_core.sv
tb/sv/morse_key_decoder_core_test.sv
